### hdl/urbc_pkg.sv
// Shared types and constants for the UART ring buffer controller.
`default_nettype none

package urbc_pkg;

  localparam int unsigned TX_DEPTH_DEF = 256;
  localparam int unsigned RX_DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    KIND_HOST_WR  = 3'd0,
    KIND_HOST_RD  = 3'd1,
    KIND_LINE_IN  = 3'd2,
    KIND_TX_EMPTY = 3'd3,
    KIND_TX_DONE  = 3'd4,
    KIND_TX_CLR   = 3'd5,
    KIND_RX_CLR   = 3'd6
  } kind_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic read_valid;
    logic tx_strobe;
    logic accepted;
    logic sending;
    logic txe_irq_en;
    logic tc_irq_en;
    logic driver_enable;
  } flags_t;

endpackage

`default_nettype wire

### hdl/uart_ring_buffer_controller.sv
// Top level of the UART transmit and receive ring buffer controller.
// Each request on the in_ channel is one host access or one UART event: a host
// byte write, a host byte read, a byte from the line, a transmit-empty or
// transmit-complete event, or a clear of either ring. Every request gives
// exactly one result on the out_ channel, carrying the byte read or sent and
// the ring levels and interrupt enables after that request.
// A request is taken into an input register and decoded from there; once the
// output register is free, the ring state and ring memories are updated and
// its result is held in the output register. One request can be accepted in
// every cycle while the receiver takes each result. When the receiver stalls
// the result stays in the output register, the input register still takes one
// more request, and in_ready then falls until the result is taken. Reset
// empties both rings, clears all flags and rs485_mode; the ring contents are
// not cleared, and no entry is read before it has been written. rs485_mode is
// to be written through cfg_wr_en only while idle; nothing here enforces it.
`default_nettype none

module uart_ring_buffer_controller #(
  parameter int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_rs485_mode,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_kind,
  input  wire logic [7:0]                      in_data,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [7:0]                      out_byte,
  output logic                                 out_read_valid,
  output logic                                 out_tx_strobe,
  output logic                                 out_accepted,
  output logic      [$clog2(TX_DEPTH + 1)-1:0] out_tx_level,
  output logic      [$clog2(RX_DEPTH + 1)-1:0] out_rx_level,
  output logic                                 out_sending,
  output logic                                 out_txe_irq_en,
  output logic                                 out_tc_irq_en,
  output logic                                 out_driver_enable
);

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);

  logic             rs485_mode_r;
  logic             item_vld_r;
  urbc_pkg::item_t  item_r;
  logic             res_vld_r;
  urbc_pkg::flags_t flags_r;
  urbc_pkg::flags_t flags_nxt;
  logic [TX_CW-1:0] tx_level_r, tx_level_nxt;
  logic [RX_CW-1:0] rx_level_r, rx_level_nxt;
  logic             commit;
  logic             tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
  logic [TX_AW-1:0] tx_wr_addr, tx_rd_addr;
  logic [RX_AW-1:0] rx_wr_addr, rx_rd_addr;
  logic [7:0]       tx_rd_data, rx_rd_data;

  assign commit   = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs485_mode_r <= 1'b0;
      item_vld_r   <= 1'b0;
      res_vld_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rs485_mode_r <= cfg_rs485_mode;
      end
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (commit) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind <= in_kind;
      item_r.data <= in_data;
      item_r.last <= in_last;
    end
    if (commit) begin
      flags_r    <= flags_nxt;
      tx_level_r <= tx_level_nxt;
      rx_level_r <= rx_level_nxt;
    end
  end

  urbc_ctrl #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH),
    .TX_AW    (TX_AW),
    .RX_AW    (RX_AW),
    .TX_CW    (TX_CW),
    .RX_CW    (RX_CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (commit),
    .item         (item_r),
    .rs485_mode   (rs485_mode_r),
    .tx_wr_en     (tx_wr_en),
    .tx_wr_addr   (tx_wr_addr),
    .tx_rd_en     (tx_rd_en),
    .tx_rd_addr   (tx_rd_addr),
    .rx_wr_en     (rx_wr_en),
    .rx_wr_addr   (rx_wr_addr),
    .rx_rd_en     (rx_rd_en),
    .rx_rd_addr   (rx_rd_addr),
    .flags_nxt    (flags_nxt),
    .tx_level_nxt (tx_level_nxt),
    .rx_level_nxt (rx_level_nxt)
  );

  urbc_ring_mem #(
    .DEPTH (TX_DEPTH),
    .AW    (TX_AW)
  ) u_tx_mem (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_wr_addr),
    .wr_data (item_r.data),
    .rd_en   (tx_rd_en),
    .rd_addr (tx_rd_addr),
    .rd_data (tx_rd_data)
  );

  urbc_ring_mem #(
    .DEPTH (RX_DEPTH),
    .AW    (RX_AW)
  ) u_rx_mem (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_wr_addr),
    .wr_data (item_r.data),
    .rd_en   (rx_rd_en),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd_data)
  );

  assign out_valid         = res_vld_r;
  assign out_byte          = flags_r.read_valid ? rx_rd_data :
                             flags_r.tx_strobe  ? tx_rd_data : 8'd0;
  assign out_read_valid    = flags_r.read_valid;
  assign out_tx_strobe     = flags_r.tx_strobe;
  assign out_accepted      = flags_r.accepted;
  assign out_tx_level      = tx_level_r;
  assign out_rx_level      = rx_level_r;
  assign out_sending       = flags_r.sending;
  assign out_txe_irq_en    = flags_r.txe_irq_en;
  assign out_tc_irq_en     = flags_r.tc_irq_en;
  assign out_driver_enable = flags_r.driver_enable;

endmodule

`default_nettype wire

### hdl/urbc_ring_mem.sv
// Byte-wide ring storage with one write port and one registered read port.
`default_nettype none

module urbc_ring_mem #(
  parameter int unsigned DEPTH = urbc_pkg::TX_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/urbc_ctrl.sv
// Ring indices, counts and interrupt flags, updated once for each request.
`default_nettype none

module urbc_ctrl #(
  parameter int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_AW    = $clog2(TX_DEPTH),
  parameter int unsigned RX_AW    = $clog2(RX_DEPTH),
  parameter int unsigned TX_CW    = $clog2(TX_DEPTH + 1),
  parameter int unsigned RX_CW    = $clog2(RX_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 commit,
  input  wire urbc_pkg::item_t      item,
  input  wire logic                 rs485_mode,
  output logic                      tx_wr_en,
  output logic         [TX_AW-1:0]  tx_wr_addr,
  output logic                      tx_rd_en,
  output logic         [TX_AW-1:0]  tx_rd_addr,
  output logic                      rx_wr_en,
  output logic         [RX_AW-1:0]  rx_wr_addr,
  output logic                      rx_rd_en,
  output logic         [RX_AW-1:0]  rx_rd_addr,
  output urbc_pkg::flags_t          flags_nxt,
  output logic         [TX_CW-1:0]  tx_level_nxt,
  output logic         [RX_CW-1:0]  rx_level_nxt
);

  logic [TX_AW-1:0] tx_wr_idx_r, tx_wr_idx_nxt, tx_rd_idx_r, tx_rd_idx_nxt;
  logic [RX_AW-1:0] rx_wr_idx_r, rx_wr_idx_nxt, rx_rd_idx_r, rx_rd_idx_nxt;
  logic [TX_CW-1:0] tx_count_r, tx_count_nxt;
  logic [RX_CW-1:0] rx_count_r, rx_count_nxt;
  logic             sending_r, sending_nxt;
  logic             txe_en_r, txe_en_nxt;
  logic             tc_en_r, tc_en_nxt;
  logic             drv_r, drv_nxt;
  logic             accepted;
  logic             read_valid;
  logic             tx_send;
  logic             tx_wr_idx_end, tx_rd_idx_end, rx_wr_idx_end, rx_rd_idx_end;

  assign tx_wr_idx_end = (tx_wr_idx_r == TX_AW'(TX_DEPTH - 1));
  assign tx_rd_idx_end = (tx_rd_idx_r == TX_AW'(TX_DEPTH - 1));
  assign rx_wr_idx_end = (rx_wr_idx_r == RX_AW'(RX_DEPTH - 1));
  assign rx_rd_idx_end = (rx_rd_idx_r == RX_AW'(RX_DEPTH - 1));

  always_comb begin
    tx_wr_idx_nxt = tx_wr_idx_r;
    tx_rd_idx_nxt = tx_rd_idx_r;
    tx_count_nxt  = tx_count_r;
    rx_wr_idx_nxt = rx_wr_idx_r;
    rx_rd_idx_nxt = rx_rd_idx_r;
    rx_count_nxt  = rx_count_r;
    sending_nxt   = sending_r;
    txe_en_nxt    = txe_en_r;
    tc_en_nxt     = tc_en_r;
    drv_nxt       = drv_r;
    accepted      = 1'b0;
    read_valid    = 1'b0;
    tx_send       = 1'b0;
    rx_wr_en      = 1'b0;

    case (urbc_pkg::kind_t'(item.kind))
      urbc_pkg::KIND_HOST_WR: begin
        if (rs485_mode) begin
          drv_nxt = 1'b1;
        end
        if (tx_count_r != TX_CW'(TX_DEPTH)) begin
          accepted      = 1'b1;
          tx_wr_idx_nxt = tx_wr_idx_end ? '0 : tx_wr_idx_r + TX_AW'(1);
          tx_count_nxt  = tx_count_r + TX_CW'(1);
        end else begin
          txe_en_nxt = 1'b1;
        end
        if (item.last) begin
          txe_en_nxt = 1'b1;
        end
      end
      urbc_pkg::KIND_HOST_RD: begin
        if (rx_count_r != '0) begin
          read_valid    = 1'b1;
          rx_rd_idx_nxt = rx_rd_idx_end ? '0 : rx_rd_idx_r + RX_AW'(1);
          rx_count_nxt  = rx_count_r - RX_CW'(1);
        end
      end
      urbc_pkg::KIND_LINE_IN: begin
        rx_wr_en      = commit;
        rx_wr_idx_nxt = rx_wr_idx_end ? '0 : rx_wr_idx_r + RX_AW'(1);
        if (rx_count_r != RX_CW'(RX_DEPTH)) begin
          rx_count_nxt = rx_count_r + RX_CW'(1);
        end
      end
      urbc_pkg::KIND_TX_EMPTY: begin
        if (txe_en_r) begin
          if (tx_count_r == '0) begin
            txe_en_nxt = 1'b0;
            tc_en_nxt  = 1'b1;
          end else begin
            sending_nxt = 1'b1;
            tx_send     = 1'b1;
          end
        end
      end
      urbc_pkg::KIND_TX_DONE: begin
        if (tc_en_r) begin
          if (tx_count_r == '0) begin
            tc_en_nxt   = 1'b0;
            sending_nxt = 1'b0;
            if (rs485_mode) begin
              drv_nxt = 1'b0;
            end
          end else begin
            tx_send = 1'b1;
          end
        end
      end
      urbc_pkg::KIND_TX_CLR: begin
        tx_wr_idx_nxt = '0;
        tx_rd_idx_nxt = '0;
        tx_count_nxt  = '0;
      end
      urbc_pkg::KIND_RX_CLR: begin
        rx_wr_idx_nxt = '0;
        rx_rd_idx_nxt = '0;
        rx_count_nxt  = '0;
      end
      default: begin
      end
    endcase

    if (tx_send) begin
      tx_rd_idx_nxt = tx_rd_idx_end ? '0 : tx_rd_idx_r + TX_AW'(1);
      tx_count_nxt  = tx_count_r - TX_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_idx_r <= '0;
      tx_rd_idx_r <= '0;
      tx_count_r  <= '0;
      rx_wr_idx_r <= '0;
      rx_rd_idx_r <= '0;
      rx_count_r  <= '0;
      sending_r   <= 1'b0;
      txe_en_r    <= 1'b0;
      tc_en_r     <= 1'b0;
      drv_r       <= 1'b0;
    end else if (commit) begin
      tx_wr_idx_r <= tx_wr_idx_nxt;
      tx_rd_idx_r <= tx_rd_idx_nxt;
      tx_count_r  <= tx_count_nxt;
      rx_wr_idx_r <= rx_wr_idx_nxt;
      rx_rd_idx_r <= rx_rd_idx_nxt;
      rx_count_r  <= rx_count_nxt;
      sending_r   <= sending_nxt;
      txe_en_r    <= txe_en_nxt;
      tc_en_r     <= tc_en_nxt;
      drv_r       <= drv_nxt;
    end
  end

  assign tx_wr_en   = commit && accepted;
  assign tx_wr_addr = tx_wr_idx_r;
  assign tx_rd_en   = commit && tx_send;
  assign tx_rd_addr = tx_rd_idx_r;
  assign rx_wr_addr = rx_wr_idx_r;
  assign rx_rd_en   = commit && read_valid;
  assign rx_rd_addr = rx_rd_idx_r;

  assign flags_nxt.read_valid    = read_valid;
  assign flags_nxt.tx_strobe     = tx_send;
  assign flags_nxt.accepted      = accepted;
  assign flags_nxt.sending       = sending_nxt;
  assign flags_nxt.txe_irq_en    = txe_en_nxt;
  assign flags_nxt.tc_irq_en     = tc_en_nxt;
  assign flags_nxt.driver_enable = drv_nxt;
  assign tx_level_nxt            = tx_count_nxt;
  assign rx_level_nxt            = rx_count_nxt;

endmodule

`default_nettype wire

### hdl/urbc_checker.sv
// Port-level checks for the UART ring buffer controller, bound to the top level.
`default_nettype none

module urbc_checker #(
  parameter int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            cfg_wr_en,
  input wire logic                            cfg_rs485_mode,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [2:0]                      in_kind,
  input wire logic [7:0]                      in_data,
  input wire logic                            in_last,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [7:0]                      out_byte,
  input wire logic                            out_read_valid,
  input wire logic                            out_tx_strobe,
  input wire logic                            out_accepted,
  input wire logic [$clog2(TX_DEPTH + 1)-1:0] out_tx_level,
  input wire logic [$clog2(RX_DEPTH + 1)-1:0] out_rx_level,
  input wire logic                            out_sending,
  input wire logic                            out_txe_irq_en,
  input wire logic                            out_tc_irq_en,
  input wire logic                            out_driver_enable
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_level) && $stable(out_rx_level))
    else $error("Result changed while stalled.");

  a_one_byte_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_valid && out_tx_strobe))
    else $error("Read and transmit byte in one result.");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid && !out_tx_strobe |-> out_byte == 8'd0)
    else $error("Byte reported without a read or a transmit.");

  a_accept_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_tx_level != '0)
    else $error("Stored byte left an empty transmit ring.");

endmodule

bind uart_ring_buffer_controller urbc_checker #(
  .TX_DEPTH (TX_DEPTH),
  .RX_DEPTH (RX_DEPTH)
) u_urbc_checker (.*);

`default_nettype wire

### test/uart_ring_buffer_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UART ring buffer controller with directed and random requests.
module uart_ring_buffer_controller_tb;

  localparam int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF;
  localparam int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    logic [7:0] obyte;
    logic       rd_valid;
    logic       strobe;
    logic       acc;
    logic [8:0] tx_lvl;
    logic [8:0] rx_lvl;
    logic       busy;
    logic       txe;
    logic       tc;
    logic       drv;
  } uart_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_rs485_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_kind = '0;
  logic [7:0] in_data = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_read_valid;
  logic       out_tx_strobe;
  logic       out_accepted;
  logic [8:0] out_tx_level;
  logic [8:0] out_rx_level;
  logic       out_sending;
  logic       out_txe_irq_en;
  logic       out_tc_irq_en;
  logic       out_driver_enable;

  uart_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  logic [7:0]  tx_mem [TX_DEPTH];
  logic [7:0]  rx_mem [RX_DEPTH];
  int unsigned tx_wr = 0, tx_rd = 0, tx_cnt = 0;
  int unsigned rx_wr = 0, rx_rd = 0, rx_cnt = 0;
  logic        sending_q = 1'b0, txe_q = 1'b0, tc_q = 1'b0, drv_q = 1'b0;
  logic        rs485_q = 1'b0;

  uart_ring_buffer_controller i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_rs485_mode    (cfg_rs485_mode),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data           (in_data),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_read_valid    (out_read_valid),
    .out_tx_strobe     (out_tx_strobe),
    .out_accepted      (out_accepted),
    .out_tx_level      (out_tx_level),
    .out_rx_level      (out_rx_level),
    .out_sending       (out_sending),
    .out_txe_irq_en    (out_txe_irq_en),
    .out_tc_irq_en     (out_tc_irq_en),
    .out_driver_enable (out_driver_enable)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] tx_pop();
    logic [7:0] b;
    b = tx_mem[tx_rd];
    tx_rd = (tx_rd + 1) % TX_DEPTH;
    tx_cnt--;
    return b;
  endfunction

  function automatic uart_result_t step_uart(logic [2:0] kind, logic [7:0] data,
                                             logic last);
    uart_result_t r;
    r = '{default: '0};
    case (kind)
      urbc_pkg::KIND_HOST_WR: begin
        if (rs485_q) drv_q = 1'b1;
        if (tx_cnt < TX_DEPTH) begin
          tx_mem[tx_wr] = data;
          tx_wr = (tx_wr + 1) % TX_DEPTH;
          tx_cnt++;
          r.acc = 1'b1;
        end else begin
          txe_q = 1'b1;
        end
        if (last) txe_q = 1'b1;
      end
      urbc_pkg::KIND_HOST_RD: begin
        if (rx_cnt != 0) begin
          r.obyte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
          rx_cnt--;
          r.rd_valid = 1'b1;
        end
      end
      urbc_pkg::KIND_LINE_IN: begin
        rx_mem[rx_wr] = data;
        rx_wr = (rx_wr + 1) % RX_DEPTH;
        if (rx_cnt < RX_DEPTH) rx_cnt++;
      end
      urbc_pkg::KIND_TX_EMPTY: begin
        if (txe_q) begin
          if (tx_cnt == 0) begin
            txe_q = 1'b0;
            tc_q = 1'b1;
          end else begin
            sending_q = 1'b1;
            r.obyte = tx_pop();
            r.strobe = 1'b1;
          end
        end
      end
      urbc_pkg::KIND_TX_DONE: begin
        if (tc_q) begin
          if (tx_cnt == 0) begin
            tc_q = 1'b0;
            if (rs485_q) drv_q = 1'b0;
            sending_q = 1'b0;
          end else begin
            r.obyte = tx_pop();
            r.strobe = 1'b1;
          end
        end
      end
      urbc_pkg::KIND_TX_CLR: begin
        tx_wr = 0;
        tx_rd = 0;
        tx_cnt = 0;
      end
      urbc_pkg::KIND_RX_CLR: begin
        rx_wr = 0;
        rx_rd = 0;
        rx_cnt = 0;
      end
      default: begin
      end
    endcase
    r.tx_lvl = 9'(tx_cnt);
    r.rx_lvl = 9'(rx_cnt);
    r.busy = sending_q;
    r.txe = txe_q;
    r.tc = tc_q;
    r.drv = drv_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
  endtask

  task automatic check_result();
    uart_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, out_byte", out_byte, 0);
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    if (out_byte !== want.obyte) report_mismatch("out_byte", out_byte, want.obyte);
    if (out_read_valid !== want.rd_valid)
      report_mismatch("out_read_valid", out_read_valid, want.rd_valid);
    if (out_tx_strobe !== want.strobe)
      report_mismatch("out_tx_strobe", out_tx_strobe, want.strobe);
    if (out_accepted !== want.acc) report_mismatch("out_accepted", out_accepted, want.acc);
    if (out_tx_level !== want.tx_lvl)
      report_mismatch("out_tx_level", out_tx_level, want.tx_lvl);
    if (out_rx_level !== want.rx_lvl)
      report_mismatch("out_rx_level", out_rx_level, want.rx_lvl);
    if (out_sending !== want.busy) report_mismatch("out_sending", out_sending, want.busy);
    if (out_txe_irq_en !== want.txe)
      report_mismatch("out_txe_irq_en", out_txe_irq_en, want.txe);
    if (out_tc_irq_en !== want.tc) report_mismatch("out_tc_irq_en", out_tc_irq_en, want.tc);
    if (out_driver_enable !== want.drv)
      report_mismatch("out_driver_enable", out_driver_enable, want.drv);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** uart_ring_buffer_controller: FAILED **");
      $finish;
    end
  end

  task automatic send_req(input logic [2:0] kind, input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data <= data;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(step_uart(kind, data, last));
    requests_sent++;
  endtask

  task automatic send_noise();
    send_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rs485_mode(input logic mode);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_rs485_mode <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rs485_q = mode;
  endtask

  task automatic test_directed();
    send_req(urbc_pkg::KIND_HOST_RD, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_EMPTY, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'hFF, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'hA5, 1'b1);
    send_req(urbc_pkg::KIND_LINE_IN, 8'hFF, 1'b0);
    send_req(urbc_pkg::KIND_LINE_IN, 8'h00, 1'b1);
    send_req(urbc_pkg::KIND_HOST_RD, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_RD, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_RD, 8'h00, 1'b0);
    repeat (4) send_req(urbc_pkg::KIND_TX_EMPTY, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'h5A, 1'b1);
    send_req(urbc_pkg::KIND_TX_EMPTY, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_EMPTY, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'h3C, 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_HOST_WR, 8'h11, 1'b0);
    send_req(urbc_pkg::KIND_LINE_IN, 8'h22, 1'b0);
    send_req(urbc_pkg::KIND_TX_CLR, 8'h00, 1'b0);
    send_req(urbc_pkg::KIND_RX_CLR, 8'h00, 1'b0);
    send_req(KIND_UNUSED, 8'hFF, 1'b1);
  endtask

  task automatic test_full_rings();
    for (int i = 0; i < TX_DEPTH + 2; i++)
      send_req(urbc_pkg::KIND_HOST_WR, 8'($urandom), i == TX_DEPTH + 1);
    for (int i = 0; i < RX_DEPTH + 2; i++)
      send_req(urbc_pkg::KIND_LINE_IN, 8'($urandom), 1'($urandom));
    for (int i = 0; i < RX_DEPTH + 1; i++)
      send_req(urbc_pkg::KIND_HOST_RD, 8'($urandom), 1'b0);
    for (int i = 0; i < TX_DEPTH + 1; i++)
      send_req(urbc_pkg::KIND_TX_EMPTY, 8'($urandom), 1'b0);
    send_req(urbc_pkg::KIND_TX_DONE, 8'h00, 1'b0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    repeat (40) send_noise();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int n);
    int start;
    int sel;
    int len;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = requests_sent;
    while (requests_sent - start < n) begin
      sel = $urandom_range(0, 19);
      len = $urandom_range(1, 12);
      if (sel < 5) begin
        for (int i = 0; i < len; i++)
          send_req(urbc_pkg::KIND_HOST_WR, 8'($urandom),
                   (i == len - 1) && ($urandom_range(0, 7) != 0));
      end else if (sel < 9) begin
        repeat (len) send_req(urbc_pkg::KIND_TX_EMPTY, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 3))
          send_req(urbc_pkg::KIND_TX_DONE, 8'($urandom), 1'($urandom));
      end else if (sel < 13) begin
        repeat (len) send_req(urbc_pkg::KIND_LINE_IN, 8'($urandom), 1'($urandom));
      end else if (sel < 16) begin
        repeat (len) send_req(urbc_pkg::KIND_HOST_RD, 8'($urandom), 1'($urandom));
      end else if (sel < 18) begin
        repeat (len / 2 + 1) send_req(urbc_pkg::KIND_TX_DONE, 8'($urandom), 1'($urandom));
      end else if (sel == 18 && $urandom_range(0, 3) == 0) begin
        send_req($urandom_range(0, 1) ? urbc_pkg::KIND_TX_CLR : urbc_pkg::KIND_RX_CLR,
                 8'($urandom), 1'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_rs485_mode(1'b0);
    test_directed();
    write_rs485_mode(1'b1);
    test_full_rings();
    wait_drained();
    test_backpressure();
    write_rs485_mode(1'b0);
    test_random(0, 0, 215);
    write_rs485_mode(1'b1);
    test_random(73, 0, 215);
    write_rs485_mode(1'b0);
    test_random(0, 73, 215);
    write_rs485_mode(1'b1);
    test_random(21, 21, 215);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** uart_ring_buffer_controller: PASSED **");
    end else begin
      $display("** uart_ring_buffer_controller: FAILED **");
    end
    $finish;
  end

endmodule
